### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: controller states,
// multiply operations and the command and status bundles.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_SCAN,
    S_MUL_ACC,
    S_SQUARE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_ACC,
    OP_SQR
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    op_t  mul_op;
    logic mul_step;
    logic exp_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic mul_last;
  } stat_t;

endpackage

### rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for right-to-left square and multiply: issues multiplies to the
// datapath, steps the exponent and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mexp_pkg::stat_t  st,
  output mexp_pkg::cmd_t   cmd
);

  mexp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mexp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != mexp_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_op    = mexp_pkg::OP_REDUCE;
    case (state)
      mexp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mexp_pkg::S_CHECK;
        end
      end
      mexp_pkg::S_CHECK: begin
        if (st.exp_zero || st.mod_zero) begin
          state_next = mexp_pkg::S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = mexp_pkg::OP_REDUCE;
          state_next    = mexp_pkg::S_REDUCE;
        end
      end
      mexp_pkg::S_REDUCE: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) begin
          state_next = mexp_pkg::S_SCAN;
        end
      end
      mexp_pkg::S_SCAN: begin
        if (st.exp_zero) begin
          state_next = mexp_pkg::S_FINISH;
        end else if (st.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = mexp_pkg::OP_ACC;
          state_next    = mexp_pkg::S_MUL_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = mexp_pkg::OP_SQR;
          state_next    = mexp_pkg::S_SQUARE;
        end
      end
      mexp_pkg::S_MUL_ACC: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = mexp_pkg::OP_SQR;
          state_next    = mexp_pkg::S_SQUARE;
        end
      end
      mexp_pkg::S_SQUARE: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) begin
          cmd.exp_shift = 1'b1;
          state_next    = mexp_pkg::S_SCAN;
        end
      end
      mexp_pkg::S_FINISH: begin
        if (!(out_valid && out_stall)) begin
          cmd.out_load = 1'b1;
          state_next   = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Operand registers, exponent shifter and a bit-serial interleaved modular
// multiplier (one multiplier bit per cycle), plus the result register.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                 clk,
  input  logic [MOD_BITS-1:0]  base,
  input  logic [EXP_BITS-1:0]  exponent,
  input  logic [MOD_BITS-1:0]  modulus,
  input  mexp_pkg::cmd_t       cmd,
  output mexp_pkg::stat_t      st,
  output logic [MOD_BITS-1:0]  power_mod
);

  localparam int CW = $clog2(MOD_BITS + 1);
  localparam int W  = MOD_BITS + 3;

  logic [MOD_BITS-1:0] base_r;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] mod;
  logic [EXP_BITS-1:0] exp_sh;
  logic [MOD_BITS-1:0] x_sh;
  logic [MOD_BITS-1:0] y;
  logic [MOD_BITS-1:0] r;
  logic [CW-1:0]       cnt;
  mexp_pkg::op_t       wb_op;

  logic [W-1:0]        t;
  logic [W-1:0]        d1;
  logic [W-1:0]        d2;
  logic [MOD_BITS-1:0] r_next;

  // r < m and y <= m keep t below 3m: at most two subtractions of m.
  always_comb begin
    t = {2'b00, r, 1'b0} + (x_sh[MOD_BITS-1] ? {3'b000, y} : '0);
    d1 = t - {3'b000, mod};
    d2 = t - {2'b00, mod, 1'b0};
    if (!d2[W-1]) begin
      r_next = d2[MOD_BITS-1:0];
    end else if (!d1[W-1]) begin
      r_next = d1[MOD_BITS-1:0];
    end else begin
      r_next = t[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base;
      mod    <= modulus;
      exp_sh <= exponent;
      acc    <= ((modulus == '0) && (exponent != '0)) ? '0 : MOD_BITS'(1);
    end
    if (cmd.exp_shift) begin
      exp_sh <= exp_sh >> 1;
    end
    if (cmd.mul_step) begin
      x_sh <= x_sh << 1;
      r    <= r_next;
      cnt  <= cnt - CW'(1);
      if (st.mul_last) begin
        case (wb_op)
          mexp_pkg::OP_ACC: acc    <= r_next;
          default:          base_r <= r_next;
        endcase
      end
    end
    if (cmd.mul_start) begin
      r     <= '0;
      cnt   <= CW'(MOD_BITS);
      wb_op <= cmd.mul_op;
      case (cmd.mul_op)
        mexp_pkg::OP_REDUCE: begin
          x_sh <= base_r;
          y    <= MOD_BITS'(1);
        end
        mexp_pkg::OP_ACC: begin
          x_sh <= acc;
          y    <= base_r;
        end
        default: begin
          x_sh <= base_r;
          y    <= base_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      power_mod <= acc;
    end
  end

  assign st.exp_zero = (exp_sh == '0);
  assign st.exp_lsb  = exp_sh[0];
  assign st.mod_zero = (mod == '0);
  assign st.mul_last = (cnt == CW'(1));

endmodule

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square and multiply
// on a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, base,       | into block
//           | exponent, modulus               |
//   out     | out_valid, out_stall, power_mod | out of block
//
// Each multiply runs one multiplier bit per cycle.
// An item runs a reduction of the base, then for each exponent bit up to the top
// set bit a multiply if the bit is set and then a square; exponent zero or modulus
// zero skips the multiplies. The input stalls until the item has finished.
// Synchronous reset clears the controller and the output valid flag.
// A stalled result waits in the output register while the next item runs.
module modular_exponentiation #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MOD_BITS-1:0] base,
  input  logic [EXP_BITS-1:0] exponent,
  input  logic [MOD_BITS-1:0] modulus,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] power_mod
);

  mexp_pkg::cmd_t  cmd;
  mexp_pkg::stat_t st;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mexp_dp #(
    .MOD_BITS (MOD_BITS),
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk       (clk),
    .base      (base),
    .exponent  (exponent),
    .modulus   (modulus),
    .cmd       (cmd),
    .st        (st),
    .power_mod (power_mod)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item in flight");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a result load");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation. A short table of directed
// operands (zero and full-range exponents, modulus of zero, one and the top
// value, bases above the modulus) is followed by random operands sent under
// four idle patterns. A long output hold then fills the block. Every result
// is checked against a table value or a square-and-multiply predictor in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MB          = 31;
  localparam int EB          = 32;
  localparam int NUM_DIR     = 24;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_ITEMS  = 6;
  localparam int HOLD_CYCLES = 6000;
  localparam int DRAIN_WAIT  = 2100;
  localparam int STALL_LIMIT = 20000;

  localparam bit [MB-1:0] MAX_M = {MB{1'b1}};
  localparam bit [EB-1:0] MAX_E = {EB{1'b1}};

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH,
    IDLE_HOLD
  } idle_mode_t;

  typedef struct {
    bit [MB-1:0] b;
    bit [EB-1:0] e;
    bit [MB-1:0] m;
    bit          known;
    bit [MB-1:0] result;
  } op_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [MB-1:0] base = '0;
  logic [EB-1:0] exponent = '0;
  logic [MB-1:0] modulus = 31'd1;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [MB-1:0] power_mod;

  idle_mode_t    idle_mode = IDLE_NONE;
  bit            hold_over = 1'b0;
  bit [MB-1:0]   power_mod_expected[$];
  int            items_sent = 0;
  int            results_checked = 0;
  int            fail_count = 0;
  int            quiet_cycles = 0;

  op_row_t dir_table [NUM_DIR] = '{
    '{31'd0,         32'd0,         31'd1,          1'b1, 31'd1},
    '{MAX_M,         32'd0,         MAX_M,          1'b1, 31'd1},
    '{31'd7,         32'd0,         31'd0,          1'b1, 31'd1},
    '{31'd7,         32'd3,         31'd0,          1'b1, 31'd0},
    '{MAX_M,         MAX_E,         31'd0,          1'b1, 31'd0},
    '{31'd12345,     32'd99,        31'd1,          1'b1, 31'd0},
    '{MAX_M,         MAX_E,         31'd1,          1'b1, 31'd0},
    '{MAX_M,         32'd1,         MAX_M,          1'b1, 31'd0},
    '{MAX_M,         MAX_E,         MAX_M,          1'b1, 31'd0},
    '{31'd0,         32'd5,         31'd13,         1'b1, 31'd0},
    '{31'd0,         MAX_E,         MAX_M,          1'b1, 31'd0},
    '{31'd1,         MAX_E,         MAX_M,          1'b1, 31'd1},
    '{31'd2,         32'd10,        MAX_M,          1'b1, 31'd1024},
    '{31'd10,        32'd1,         31'd7,          1'b1, 31'd3},
    '{31'd2,         32'd30,        MAX_M,          1'b1, 31'd1073741824},
    '{31'd2,         32'd31,        MAX_M,          1'b1, 31'd1},
    '{MAX_M,         32'd2,         31'h7FFF_FFFE,  1'b1, 31'd1},
    '{31'd3,         32'h8000_0000, MAX_M,          1'b0, 31'd0},
    '{31'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAB,  1'b0, 31'd0},
    '{31'h2AAA_AAAA, 32'h5555_5555, 31'h7FFF_FFF1,  1'b0, 31'd0},
    '{31'h1234_5678, MAX_E,         31'd2,          1'b0, 31'd0},
    '{MAX_M,         MAX_E,         31'h4000_0000,  1'b0, 31'd0},
    '{31'h4000_0000, 32'd3,         31'h7FFF_FFED,  1'b0, 31'd0},
    '{31'd65537,     32'd65537,     31'd3,          1'b0, 31'd0}
  };

  modular_exponentiation #(
    .MOD_BITS(MB),
    .EXP_BITS(EB)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .base     (base),
    .exponent (exponent),
    .modulus  (modulus),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_mod(power_mod)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit [MB-1:0] predict_power_mod(input bit [MB-1:0] b,
                                                    input bit [EB-1:0] e,
                                                    input bit [MB-1:0] m);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [63:0] mm;
    acc = 64'd1;
    sq  = 64'(b);
    mm  = 64'(m);
    if (e == '0) return MB'(1);
    if (m == '0) return '0;
    for (int i = 0; i < EB; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[MB-1:0];
  endfunction

  // Offer one operand set and hold it until the transfer.
  task automatic offer_operands(input bit [MB-1:0] b, input bit [EB-1:0] e,
                                input bit [MB-1:0] m, input bit known,
                                input bit [MB-1:0] known_val);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 52 : (idle_mode == IDLE_BOTH) ? 14 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    modulus  <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    power_mod_expected.push_back(known ? known_val : predict_power_mod(b, e, m));
    items_sent++;
  endtask

  task automatic random_operands(output bit [MB-1:0] b, output bit [EB-1:0] e,
                                 output bit [MB-1:0] m);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: m = MB'($urandom_range(1, MAX_M));
      6, 7:             m = MB'($urandom_range(1, 16));
      default:          m = MAX_M - MB'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: b = MB'($urandom());
      7:                   b = MB'($urandom_range(0, 3));
      8:                   b = m;
      default:             b = MAX_M;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: e = $urandom();
      4, 5, 6:    e = EB'($urandom_range(0, 65535));
      7, 8:       e = EB'($urandom_range(0, 255));
      default:    e = EB'($urandom_range(0, 3));
    endcase
  endtask

  initial begin : receiver
    int stall_pct;
    forever begin
      @(posedge clk);
      if (idle_mode == IDLE_HOLD && !hold_over) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_over = 1'b1;
      end else begin
        stall_pct = (idle_mode == IDLE_RECV) ? 52 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (power_mod_expected.size() == 0) begin
        $error("power_mod: unexpected result %0d", power_mod);
        fail_count++;
      end else begin
        if (power_mod !== power_mod_expected[0]) begin
          $error("power_mod: expected %0d, actual %0d", power_mod_expected[0], power_mod);
          fail_count++;
        end
        void'(power_mod_expected.pop_front());
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    bit [MB-1:0] b;
    bit [EB-1:0] e;
    bit [MB-1:0] m;
    idle_mode_t  phase_order [4];
    phase_order = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      offer_operands(dir_table[i].b, dir_table[i].e, dir_table[i].m,
                     dir_table[i].known, dir_table[i].result);
    end

    foreach (phase_order[p]) begin
      // drop valid and pause until every result is back
      in_valid <= 1'b0;
      @(posedge clk);
      while (power_mod_expected.size() != 0) @(posedge clk);
      idle_mode = phase_order[p];
      repeat (PHASE_ITEMS) begin
        random_operands(b, e, m);
        offer_operands(b, e, m, 1'b0, '0);
      end
    end

    // hold the output side while operands keep coming
    in_valid <= 1'b0;
    @(posedge clk);
    while (power_mod_expected.size() != 0) @(posedge clk);
    idle_mode = IDLE_HOLD;
    repeat (HOLD_ITEMS) begin
      random_operands(b, e, m);
      offer_operands(b, e, 31'(m[7:0]) | 31'd1, 1'b0, '0);
    end
    wait (hold_over);

    in_valid <= 1'b0;
    @(posedge clk);
    while (power_mod_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d operand sets, checked %0d results over four idle patterns,",
             items_sent, results_checked);
    $display("a drain pause before each phase and a %0d-cycle output hold.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### modular_exponentiation.f
rtl/mexp_pkg.sv
rtl/mexp_ctrl.sv
rtl/mexp_dp.sv
rtl/modular_exponentiation.sv
bench/testbench.sv
